// ===== rtl/core/swer_pkg.sv =====
// Shared constants and types for the sliding window event rate core.
package swer_pkg;

  localparam int DepthDef    = 1024;
  localparam int TimeBitsDef = 48;
  localparam int CountW      = 11;

  localparam logic [63:0] WindowResetDef = 64'd10000000;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              overflow;
  } swer_result_t;

endpackage

// ===== rtl/core/sliding_window_event_rate_core.sv =====
// Sliding window event rate core: window register, ring RAM, controller, output register.
// A new item is taken only once the previous one has finished and its result has been accepted.
// The aging loop is set by the ring RAM's registered read: one stored stamp checked a cycle.
// After acceptance the controller ages out stale stamps, then raises res_valid; out_valid is registered from it.
// Reset clears ring pointers and occupancy and loads window_r with 10000000;
// the ring RAM is not cleared, occupancy guards every read.
module sliding_window_event_rate_core #(
  parameter int DEPTH     = swer_pkg::DepthDef,
  parameter int TIME_BITS = swer_pkg::TimeBitsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [TIME_BITS-1:0]        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [TIME_BITS-1:0]        in_timestamp,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [swer_pkg::CountW-1:0] out_events_in_window,
  output logic                        out_window_overflow
);
  import swer_pkg::*;

  localparam int SlotW = $clog2(DEPTH);

  logic [TIME_BITS-1:0] window_r, window_nxt;
  logic                 out_valid_r, out_valid_nxt;
  swer_result_t         out_r;

  logic                 res_valid;
  logic                 res_ready;
  swer_result_t         res;
  logic [SlotW-1:0]     rd_addr;
  logic [TIME_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [SlotW-1:0]     wr_addr;
  logic [TIME_BITS-1:0] wr_data;

  assign window_nxt    = cfg_wr_en ? cfg_wr_data : window_r;
  assign res_ready     = !out_valid_r || !out_stall;
  assign out_valid_nxt = res_valid ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WindowResetDef[TIME_BITS-1:0];
      out_valid_r <= 1'b0;
    end else begin
      window_r    <= window_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_events_in_window = out_r.count;
  assign out_window_overflow  = out_r.overflow;

  swer_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  swer_ctrl #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .window_len   (window_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_timestamp (in_timestamp),
    .in_restart   (in_restart),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

endmodule

// ===== rtl/core/swer_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
module swer_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/swer_ctrl.sv =====
// Ring controller: ages out old stamps from the ring RAM and pushes the new one.
module swer_ctrl #(
  parameter int DEPTH     = 1024,
  parameter int TIME_BITS = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [TIME_BITS-1:0]       window_len,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [TIME_BITS-1:0]       in_timestamp,
  input  logic                       in_restart,
  output logic                       res_valid,
  input  logic                       res_ready,
  output swer_pkg::swer_result_t     res,
  output logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic [TIME_BITS-1:0]       rd_data,
  output logic                       wr_en,
  output logic [$clog2(DEPTH)-1:0]   wr_addr,
  output logic [TIME_BITS-1:0]       wr_data
);
  import swer_pkg::*;

  localparam int SlotW = $clog2(DEPTH);
  localparam int OccW  = $clog2(DEPTH + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StCheck  = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [SlotW-1:0]     oldest_r, oldest_nxt;
  logic [SlotW-1:0]     newest_r, newest_nxt;
  logic [OccW-1:0]      occ_r, occ_nxt;

  logic                 accept;
  logic                 aged;
  logic                 finish;
  logic                 full;
  logic [SlotW-1:0]     oldest_inc;
  logic [SlotW-1:0]     newest_inc;
  logic [TIME_BITS-1:0] age;

  function automatic logic [SlotW-1:0] ring_next(input logic [SlotW-1:0] slot);
    ring_next = (slot == SlotW'(DEPTH - 1)) ? '0 : slot + 1'b1;
  endfunction

  assign in_stall   = (state_r != StIdle);
  assign accept     = in_valid && !in_stall;
  assign oldest_inc = ring_next(oldest_r);
  assign newest_inc = ring_next(newest_r);
  assign age        = now_r - rd_data;
  // an entry later than the new event is never aged out
  assign aged       = (now_r >= rd_data) && (age >= window_len);
  assign full       = (occ_r == OccW'(DEPTH));

  assign res.count    = CountW'(occ_r);
  assign res.overflow = full;
  assign res_valid    = finish;

  assign wr_en   = finish;
  assign wr_addr = newest_r;
  assign wr_data = now_r;

  always_comb begin
    state_nxt  = state_r;
    now_nxt    = now_r;
    oldest_nxt = oldest_r;
    newest_nxt = newest_r;
    occ_nxt    = occ_r;
    rd_addr    = oldest_r;
    finish     = 1'b0;
    unique case (state_r)
      StIdle: begin
        if (accept) begin
          now_nxt = in_timestamp;
          if (in_restart) begin
            oldest_nxt = '0;
            newest_nxt = '0;
            occ_nxt    = '0;
            state_nxt  = StFinish;
          end else if (occ_r == '0) begin
            state_nxt = StFinish;
          end else begin
            state_nxt = StCheck;
          end
        end
      end
      StCheck: begin
        if (aged) begin
          oldest_nxt = oldest_inc;
          occ_nxt    = occ_r - 1'b1;
          rd_addr    = oldest_inc;
          if (occ_r == OccW'(1)) begin
            state_nxt = StFinish;
          end
        end else if (res_ready) begin
          finish = 1'b1;
        end else begin
          state_nxt = StFinish;
        end
      end
      StFinish: begin
        if (res_ready) begin
          finish = 1'b1;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase

    if (finish) begin
      state_nxt  = StIdle;
      newest_nxt = newest_inc;
      if (full) begin
        // ring full: drop the oldest, occupancy stays at DEPTH
        oldest_nxt = oldest_inc;
        occ_nxt    = occ_r;
      end else begin
        occ_nxt = occ_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= StIdle;
      oldest_r <= '0;
      newest_r <= '0;
      occ_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      newest_r <= newest_nxt;
      occ_r    <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the sliding window event rate core: directed and random events vs a predictor.
module tb_top;
  import swer_pkg::*;

  localparam int Depth    = DepthDef;
  localparam int TimeBits = TimeBitsDef;

  typedef logic [TimeBits-1:0] stamp_t;

  localparam stamp_t TimeMax = '1;
  localparam stamp_t ResetWindow = WindowResetDef[TimeBits-1:0];

  // Tracks the ring of recent stamps and the results each event should produce.
  class window_tracker;
    stamp_t       ring [Depth];
    int unsigned  oldest_slot;
    int unsigned  newest_slot;
    int unsigned  fill;
    stamp_t       window;
    swer_result_t expected_q [$];
    int           mismatches;
    int           overflows;
    int           peak;

    function new();
      oldest_slot = 0;
      newest_slot = 0;
      fill        = 0;
      window      = ResetWindow;
      mismatches  = 0;
      overflows   = 0;
      peak        = 0;
    endfunction

    function void note_event(stamp_t now, logic restart);
      swer_result_t res;
      if (restart) begin
        oldest_slot = 0;
        newest_slot = 0;
        fill        = 0;
      end
      // drop stamps that are a full window or more behind; a later stamp stops the scan
      while (fill > 0) begin
        if (now < ring[oldest_slot] || now - ring[oldest_slot] < window) break;
        oldest_slot = (oldest_slot + 1) % Depth;
        fill--;
      end
      res.count    = CountW'(fill);
      res.overflow = 1'b0;
      if (fill >= Depth) begin
        oldest_slot  = (oldest_slot + 1) % Depth;
        fill         = Depth - 1;
        res.overflow = 1'b1;
        overflows++;
      end
      ring[newest_slot] = now;
      newest_slot = (newest_slot + 1) % Depth;
      fill++;
      if (res.count > peak) peak = res.count;
      expected_q = {expected_q, res};
    endfunction

    function void check_result(logic [CountW-1:0] count, logic overflow);
      swer_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected item: events_in_window %0d window_overflow %0b", count, overflow);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (count !== want.count) begin
        $error("events_in_window: expected %0d, actual %0d", want.count, count);
        mismatches++;
      end
      if (overflow !== want.overflow) begin
        $error("window_overflow: expected %0b, actual %0b", want.overflow, overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  stamp_t              cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  stamp_t              in_timestamp;
  logic                in_restart;
  logic                out_valid;
  logic                out_stall;
  logic [CountW-1:0]   out_events_in_window;
  logic                out_window_overflow;

  window_tracker tracker = new();
  bit calm;
  bit hold_req;
  int events_sent;
  int restarts;
  int windows_set;

  sliding_window_event_rate_core #(
    .DEPTH(Depth),
    .TIME_BITS(TimeBits)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_timestamp(in_timestamp),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_events_in_window(out_events_in_window),
    .out_window_overflow(out_window_overflow)
  );

  always #5 clk = ~clk;

  function automatic stamp_t rand_stamp();
    return stamp_t'({$urandom, $urandom});
  endfunction

  task automatic send_event(stamp_t ts, logic restart);
    in_valid     <= 1'b1;
    in_timestamp <= ts;
    in_restart   <= restart;
    do @(posedge clk); while (in_stall);
    tracker.note_event(ts, restart);
    events_sent++;
    if (restart) restarts++;
    if (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // the window may only change once every outstanding item has come back
  task automatic write_window(stamp_t w);
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_q.size() != 0);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.window = w;
    windows_set++;
  endtask

  task automatic random_run(int count, stamp_t w);
    stamp_t      ts;
    logic [63:0] step_span;
    logic [63:0] step;
    int          sel;
    step_span = ({16'b0, w} / $urandom_range(1, 40)) * 2 + 1;
    ts = $urandom_range(1) ? rand_stamp() : stamp_t'($urandom_range(1000));
    send_event(ts, 1'b1);
    for (int i = 1; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 6) begin
        ts = rand_stamp();
        send_event(ts, 1'b1);
      end else if (sel < 11) begin
        // out of order noise, leaves the sequence where it was
        send_event(rand_stamp(), 1'b0);
      end else begin
        step = ($urandom_range(9) == 0) ? 64'd0 : {$urandom, $urandom} % step_span;
        ts = ts + stamp_t'(step);
        send_event(ts, 1'b0);
      end
    end
  endtask

  initial begin : result_sink
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        tracker.check_result(out_events_in_window, out_window_overflow);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = 2500;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 14);
      end
    end
  end

  initial begin : stimulus
    stamp_t ts;
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_valid     <= 1'b0;
    in_timestamp <= '0;
    in_restart   <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window: aging at the exact boundary, out of order stamps, wrap
    send_event(48'd0, 1'b1);
    send_event(48'd0, 1'b0);
    send_event(48'd5, 1'b0);
    send_event(ResetWindow - 1, 1'b0);
    send_event(ResetWindow, 1'b0);
    send_event(48'd3, 1'b0);
    send_event(ResetWindow * 2 + 5, 1'b0);
    send_event(TimeMax, 1'b1);
    send_event(TimeMax, 1'b0);
    send_event(48'd0, 1'b0);
    send_event(48'h5555_5555_5555, 1'b1);
    send_event(48'hAAAA_AAAA_AAAA, 1'b0);

    // narrowest window: only equal stamps count
    write_window(48'd1);
    send_event(48'd100, 1'b1);
    send_event(48'd100, 1'b0);
    send_event(48'd100, 1'b0);
    send_event(48'd101, 1'b0);
    send_event(48'd101, 1'b0);

    // widest window, then a long receiver hold-off and an overrun of the ring
    write_window(TimeMax);
    send_event(48'd0, 1'b1);
    send_event(TimeMax - 1, 1'b0);
    send_event(TimeMax, 1'b0);
    hold_req = 1'b1;
    ts = stamp_t'($urandom_range(1000));
    send_event(ts, 1'b1);
    for (int i = 0; i < 1100; i++) begin
      ts = ts + stamp_t'($urandom_range(1000));
      send_event(ts, 1'b0);
    end

    for (int ph = 0; ph < 6; ph++) begin
      stamp_t w;
      case (ph % 3)
        0: w = stamp_t'($urandom_range(1, 16));
        1: w = stamp_t'($urandom_range(17, 100000));
        default: w = rand_stamp() | stamp_t'(1);
      endcase
      write_window(w);
      calm = (ph == 0);
      random_run(90, w);
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_q.size() != 0);
    repeat (100) @(posedge clk);

    $display("Sent %0d events with %0d restarts across %0d window settings.",
             events_sent, restarts, windows_set + 1);
    $display("Saw %0d ring overflows; peak events_in_window %0d.",
             tracker.overflows, tracker.peak);
    if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
